FILE: rtl/gtri_pkg.sv
// ----------------------------------------------------------------------------
// gtri_pkg
// Shared widths, status codes and pipeline control types for the gyro rate
// trapezoid integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package gtri_pkg;

  localparam int AXES       = 3;
  localparam int PORT_AXES  = 3;
  localparam int RATE_BITS  = 24;
  localparam int IN_RATE_W  = 24;
  localparam int TS_W       = 63;
  localparam int GAP_W      = 32;
  localparam int ANGLE_W    = 64;
  localparam int STATUS_W   = 3;
  localparam int RSUM_W     = RATE_BITS + 1;
  localparam int PROD_W     = RSUM_W + GAP_W + 1;
  localparam int ACC_EXT_W  = ((PROD_W > ANGLE_W) ? PROD_W : ANGLE_W) + 1;

  localparam logic [GAP_W-1:0] MAX_GAP_RESET = GAP_W'(100000000);

  typedef enum logic [STATUS_W-1:0] {
    ST_FIRST        = 3'd0,
    ST_INTEGRATED   = 3'd1,
    ST_NOT_POSITIVE = 3'd2,
    ST_GAP          = 3'd3,
    ST_SATURATED    = 3'd4
  } status_e;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } pipe_ctrl_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic integ;
    logic clear;
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/gyro_rate_trapezoid_integrator_top.sv
// Pipeline: history/interval register, product register, accumulator as the
//   output register.
// Throughput: one request per cycle unless the output stalls; each axis lane
//   has its own multiplier and accumulator register for its accumulate loop.
// Reset: history, accumulators and valid flags clear; gap limit = 100000000.
// ----------------------------------------------------------------------------
// gyro_rate_trapezoid_integrator_top
// Three-axis trapezoidal gyro rate integrator with saturating accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_rate_trapezoid_integrator_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [gtri_pkg::GAP_W-1:0]     cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [gtri_pkg::TS_W-1:0]      timestamp_ns_i,
  input  wire logic [gtri_pkg::IN_RATE_W-1:0] rate_x_i,
  input  wire logic [gtri_pkg::IN_RATE_W-1:0] rate_y_i,
  input  wire logic [gtri_pkg::IN_RATE_W-1:0] rate_z_i,
  input  wire logic                           restart_i,
  input  wire logic                           clear_angle_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [gtri_pkg::ANGLE_W-1:0]        angle_x_o,
  output logic [gtri_pkg::ANGLE_W-1:0]        angle_y_o,
  output logic [gtri_pkg::ANGLE_W-1:0]        angle_z_o,
  output logic [gtri_pkg::STATUS_W-1:0]       step_status_o
);

  logic                       v1_q, v2_q;
  logic                       s1_en, s2_en, s3_en;
  gtri_pkg::pipe_ctrl_t       front_ctrl;
  gtri_pkg::lane_ctrl_t       lane_ctrl;
  logic [gtri_pkg::GAP_W-1:0] dt;
  gtri_pkg::status_e          class2;
  logic                       clear2;
  gtri_pkg::status_e          status;
  logic [gtri_pkg::AXES-1:0]  clip;

  logic [gtri_pkg::IN_RATE_W-1:0] rate_arr  [gtri_pkg::PORT_AXES];
  logic [gtri_pkg::ANGLE_W-1:0]   angle_arr [gtri_pkg::PORT_AXES];

  assign s3_en      = v2_q & (~out_valid_o | out_ready_i);
  assign s2_en      = v1_q & (~v2_q | s3_en);
  assign in_ready_o = ~v1_q | s2_en;
  assign s1_en      = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_en) begin
        v1_q <= 1'b1;
      end else if (s2_en) begin
        v1_q <= 1'b0;
      end
      if (s2_en) begin
        v2_q <= 1'b1;
      end else if (s3_en) begin
        v2_q <= 1'b0;
      end
    end
  end

  assign front_ctrl.s1_en = s1_en;
  assign front_ctrl.s2_en = s2_en;

  assign lane_ctrl.s1_en = s1_en;
  assign lane_ctrl.s2_en = s2_en;
  assign lane_ctrl.s3_en = s3_en;
  assign lane_ctrl.integ = (class2 == gtri_pkg::ST_INTEGRATED);
  assign lane_ctrl.clear = clear2;

  gtri_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .ctrl_i    (front_ctrl),
    .timestamp_ns_i,
    .restart_i,
    .clear_angle_i,
    .dt_o      (dt),
    .class_o   (class2),
    .clear_o   (clear2)
  );

  assign rate_arr[0] = rate_x_i;
  assign rate_arr[1] = rate_y_i;
  assign rate_arr[2] = rate_z_i;

  for (genvar g = 0; g < gtri_pkg::PORT_AXES; g++) begin : g_axis
    if (g < gtri_pkg::AXES) begin : g_lane
      gtri_lane u_lane (
        .clk_i,
        .rst_ni,
        .ctrl_i  (lane_ctrl),
        .rate_i  (rate_arr[g]),
        .dt_i    (dt),
        .angle_o (angle_arr[g]),
        .clip_o  (clip[g])
      );
    end else begin : g_unused
      assign angle_arr[g] = '0;
    end
  end

  gtri_merge u_merge (
    .clk_i,
    .rst_ni,
    .s3_en_i     (s3_en),
    .out_ready_i,
    .class_i     (class2),
    .clip_i      (clip),
    .status_o    (status),
    .out_valid_o
  );

  assign angle_x_o     = angle_arr[0];
  assign angle_y_o     = angle_arr[1];
  assign angle_z_o     = angle_arr[2];
  assign step_status_o = status;

endmodule

`default_nettype wire

FILE: rtl/gtri_front.sv
// ----------------------------------------------------------------------------
// gtri_front
// Sample history, interval check against the gap limit, and the per-request
// class and clear flag carried down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gtri_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [gtri_pkg::GAP_W-1:0]   cfg_wdata_i,
  input  wire gtri_pkg::pipe_ctrl_t         ctrl_i,
  input  wire logic [gtri_pkg::TS_W-1:0]    timestamp_ns_i,
  input  wire logic                         restart_i,
  input  wire logic                         clear_angle_i,
  output logic [gtri_pkg::GAP_W-1:0]        dt_o,
  output gtri_pkg::status_e                 class_o,
  output logic                              clear_o
);

  logic [gtri_pkg::GAP_W-1:0] max_gap_q;
  logic [gtri_pkg::TS_W-1:0]  last_time_q;
  logic                       have_last_q;
  logic [gtri_pkg::TS_W:0]    diff;
  logic                       have;
  gtri_pkg::status_e          class_d;

  gtri_pkg::status_e          class1_q, class2_q;
  logic                       clear1_q, clear2_q;
  logic [gtri_pkg::GAP_W-1:0] dt1_q;

  assign diff = {1'b0, timestamp_ns_i} - {1'b0, last_time_q};
  assign have = have_last_q & ~restart_i;

  always_comb begin
    priority if (!have) begin
      class_d = gtri_pkg::ST_FIRST;
    end else if (diff[gtri_pkg::TS_W] || (diff[gtri_pkg::TS_W-1:0] == '0)) begin
      class_d = gtri_pkg::ST_NOT_POSITIVE;
    end else if (diff[gtri_pkg::TS_W-1:0] >
                 {{(gtri_pkg::TS_W-gtri_pkg::GAP_W){1'b0}}, max_gap_q}) begin
      class_d = gtri_pkg::ST_GAP;
    end else begin
      class_d = gtri_pkg::ST_INTEGRATED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q   <= gtri_pkg::MAX_GAP_RESET;
      last_time_q <= '0;
      have_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_gap_q <= cfg_wdata_i;
      end
      if (ctrl_i.s1_en) begin
        last_time_q <= timestamp_ns_i;
        have_last_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      class1_q <= class_d;
      clear1_q <= clear_angle_i;
      dt1_q    <= diff[gtri_pkg::GAP_W-1:0];
    end
    if (ctrl_i.s2_en) begin
      class2_q <= class1_q;
      clear2_q <= clear1_q;
    end
  end

  assign dt_o    = dt1_q;
  assign class_o = class2_q;
  assign clear_o = clear2_q;

endmodule

`default_nettype wire

FILE: rtl/gtri_lane.sv
// ----------------------------------------------------------------------------
// gtri_lane
// One axis: rate history and sum, rate sum times interval, and the
// saturating 64-bit rotation accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module gtri_lane (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire gtri_pkg::lane_ctrl_t           ctrl_i,
  input  wire logic [gtri_pkg::IN_RATE_W-1:0] rate_i,
  input  wire logic [gtri_pkg::GAP_W-1:0]     dt_i,
  output logic [gtri_pkg::ANGLE_W-1:0]        angle_o,
  output logic                                clip_o
);

  logic signed [gtri_pkg::RATE_BITS-1:0] rate;
  logic signed [gtri_pkg::RATE_BITS-1:0] last_rate_q;
  logic signed [gtri_pkg::RSUM_W-1:0]    rsum_q;
  logic signed [gtri_pkg::PROD_W-1:0]    prod_d, prod_q;
  logic signed [gtri_pkg::ANGLE_W-1:0]   acc_q, acc_d, base;
  logic        [gtri_pkg::ACC_EXT_W-1:0] total;
  logic        [gtri_pkg::ACC_EXT_W-gtri_pkg::ANGLE_W:0] top_bits;
  logic                                  over;

  assign rate   = gtri_pkg::RATE_BITS'(rate_i[gtri_pkg::RATE_BITS-1:0]);
  assign prod_d = rsum_q * $signed({1'b0, dt_i});
  assign base   = ctrl_i.clear ? '0 : acc_q;

  assign total =
    {{(gtri_pkg::ACC_EXT_W-gtri_pkg::ANGLE_W){base[gtri_pkg::ANGLE_W-1]}}, base} +
    {{(gtri_pkg::ACC_EXT_W-gtri_pkg::PROD_W){prod_q[gtri_pkg::PROD_W-1]}}, prod_q};

  // sign bits above bit 62 must all agree for the sum to fit
  assign top_bits = total[gtri_pkg::ACC_EXT_W-1:gtri_pkg::ANGLE_W-1];
  assign over     = (top_bits != '0) && (top_bits != '1);

  always_comb begin
    acc_d = base;
    if (ctrl_i.integ) begin
      if (over) begin
        acc_d = total[gtri_pkg::ACC_EXT_W-1] ? {1'b1, {(gtri_pkg::ANGLE_W-1){1'b0}}}
                                             : {1'b0, {(gtri_pkg::ANGLE_W-1){1'b1}}};
      end else begin
        acc_d = total[gtri_pkg::ANGLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rate_q <= '0;
      acc_q       <= '0;
    end else begin
      if (ctrl_i.s1_en) begin
        last_rate_q <= rate;
      end
      if (ctrl_i.s3_en) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      rsum_q <= gtri_pkg::RSUM_W'(last_rate_q) + gtri_pkg::RSUM_W'(rate);
    end
    if (ctrl_i.s2_en) begin
      prod_q <= prod_d;
    end
  end

  assign angle_o = acc_q;
  assign clip_o  = ctrl_i.integ & over;

endmodule

`default_nettype wire

FILE: rtl/gtri_merge.sv
// ----------------------------------------------------------------------------
// gtri_merge
// Combines the lane clip flags with the interval class into the status code
// and holds the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gtri_merge (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s3_en_i,
  input  wire logic                      out_ready_i,
  input  wire gtri_pkg::status_e         class_i,
  input  wire logic [gtri_pkg::AXES-1:0] clip_i,
  output gtri_pkg::status_e              status_o,
  output logic                           out_valid_o
);

  gtri_pkg::status_e status_d, status_q;
  logic              valid_q;

  always_comb begin
    status_d = class_i;
    if ((class_i == gtri_pkg::ST_INTEGRATED) && (|clip_i)) begin
      status_d = gtri_pkg::ST_SATURATED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s3_en_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en_i) begin
      status_q <= status_d;
    end
  end

  assign status_o    = status_q;
  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

FILE: rtl/gtri_checker.sv
// ----------------------------------------------------------------------------
// gtri_checker
// Port-level checks on the integrator: request accounting, result hold under
// stall and legal status codes.
// ----------------------------------------------------------------------------
`default_nettype none

module gtri_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_o,
  input  wire logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  input  wire logic [gtri_pkg::ANGLE_W-1:0]    angle_x_o,
  input  wire logic [gtri_pkg::ANGLE_W-1:0]    angle_y_o,
  input  wire logic [gtri_pkg::ANGLE_W-1:0]    angle_z_o,
  input  wire logic [gtri_pkg::STATUS_W-1:0]   step_status_o
);

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // no result without a request in flight
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != '0))
    else $error("result without pending request");

  // pipeline holds at most three requests
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("too many requests in flight");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(angle_x_o) &&
      $stable(angle_y_o) && $stable(angle_z_o) && $stable(step_status_o)))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (step_status_o != 3'd5 && step_status_o != 3'd6 &&
      step_status_o != 3'd7))
    else $error("illegal status code");

endmodule

bind gyro_rate_trapezoid_integrator_top gtri_checker u_gtri_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gyro rate trapezoid integrator. A queue of
// samples (directed corner cases, a saturation run, then random sequences
// under several gap limits) feeds a valid/ready driver; an in-bench model
// predicts the angles and status per accepted request and a monitor checks
// each result in order, with random idling on both sides.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 10;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS     = 10;
  localparam int IDLE_PCT        = 32;

  localparam logic [gtri_pkg::IN_RATE_W-1:0] RATE_POS_MAX =
    {1'b0, {(gtri_pkg::IN_RATE_W-1){1'b1}}};
  localparam logic [gtri_pkg::IN_RATE_W-1:0] RATE_NEG_MIN =
    {1'b1, {(gtri_pkg::IN_RATE_W-1){1'b0}}};
  localparam logic signed [127:0]  WIDE_MAX     = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0]  WIDE_MIN     = -128'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [gtri_pkg::TS_W-1:0]                                    ts;
    logic [gtri_pkg::PORT_AXES-1:0][gtri_pkg::IN_RATE_W-1:0]      rate;
    logic                                                         restart;
    logic                                                         clear;
  } sample_t;

  typedef struct packed {
    logic [gtri_pkg::PORT_AXES-1:0][gtri_pkg::ANGLE_W-1:0] angle;
    gtri_pkg::status_e                                     status;
  } angle_result_t;

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           cfg_we_i       = 1'b0;
  logic [gtri_pkg::GAP_W-1:0]     cfg_wdata_i    = '0;
  logic                           in_valid_i     = 1'b0;
  logic                           in_ready_o;
  logic [gtri_pkg::TS_W-1:0]      timestamp_ns_i = '0;
  logic [gtri_pkg::IN_RATE_W-1:0] rate_x_i       = '0;
  logic [gtri_pkg::IN_RATE_W-1:0] rate_y_i       = '0;
  logic [gtri_pkg::IN_RATE_W-1:0] rate_z_i       = '0;
  logic                           restart_i      = 1'b0;
  logic                           clear_angle_i  = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i    = 1'b0;
  logic [gtri_pkg::ANGLE_W-1:0]   angle_x_o;
  logic [gtri_pkg::ANGLE_W-1:0]   angle_y_o;
  logic [gtri_pkg::ANGLE_W-1:0]   angle_z_o;
  logic [gtri_pkg::STATUS_W-1:0]  step_status_o;

  sample_t                   pending_samples [$];
  angle_result_t             expected_angles [$];
  sample_t                   on_offer;
  logic [gtri_pkg::TS_W-1:0] gen_ts = '0;
  int            idle_pct       = IDLE_PCT;
  bit            hold_off_req   = 1'b0;
  int            hold_left      = 0;
  int            mismatch_count = 0;
  int            stall_cycles   = 0;

  // model state
  logic [gtri_pkg::GAP_W-1:0]            gap_limit = gtri_pkg::MAX_GAP_RESET;
  logic signed [gtri_pkg::RATE_BITS-1:0] hist_rate [gtri_pkg::PORT_AXES];
  logic [gtri_pkg::TS_W-1:0]             hist_ts;
  logic                                  hist_valid;
  logic signed [gtri_pkg::ANGLE_W-1:0]   angle_acc [gtri_pkg::PORT_AXES];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  gyro_rate_trapezoid_integrator_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .timestamp_ns_i (timestamp_ns_i),
    .rate_x_i       (rate_x_i),
    .rate_y_i       (rate_y_i),
    .rate_z_i       (rate_z_i),
    .restart_i      (restart_i),
    .clear_angle_i  (clear_angle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .angle_x_o      (angle_x_o),
    .angle_y_o      (angle_y_o),
    .angle_z_o      (angle_z_o),
    .step_status_o  (step_status_o)
  );

  // trapezoid step: (previous rate + rate) * dt, saturating at 64 bits
  task automatic integrate_sample(input sample_t s);
    logic signed [gtri_pkg::RATE_BITS-1:0] cur [gtri_pkg::PORT_AXES];
    logic signed [gtri_pkg::RATE_BITS:0]   rsum;
    logic [gtri_pkg::TS_W:0]               dt;
    logic signed [127:0]                   term;
    logic signed [127:0]                   wide;
    logic                                  clipped;
    angle_result_t                         r;
    for (int a = 0; a < gtri_pkg::PORT_AXES; a++)
      cur[a] = s.rate[a][gtri_pkg::RATE_BITS-1:0];
    if (s.clear) begin
      for (int a = 0; a < gtri_pkg::PORT_AXES; a++) angle_acc[a] = '0;
    end
    if (s.restart) hist_valid = 1'b0;
    clipped = 1'b0;
    dt = {1'b0, s.ts} - {1'b0, hist_ts};
    if (!hist_valid) begin
      r.status = gtri_pkg::ST_FIRST;
    end else if (s.ts <= hist_ts) begin
      r.status = gtri_pkg::ST_NOT_POSITIVE;
    end else if (dt > (gtri_pkg::TS_W+1)'(gap_limit)) begin
      r.status = gtri_pkg::ST_GAP;
    end else begin
      for (int a = 0; a < gtri_pkg::AXES; a++) begin
        rsum = hist_rate[a] + cur[a];
        term = rsum;
        term = term * $signed({1'b0, 127'(dt)});
        wide = angle_acc[a];
        wide = wide + term;
        if (wide > WIDE_MAX) begin
          angle_acc[a] = WIDE_MAX[63:0];
          clipped = 1'b1;
        end else if (wide < WIDE_MIN) begin
          angle_acc[a] = WIDE_MIN[63:0];
          clipped = 1'b1;
        end else begin
          angle_acc[a] = wide[63:0];
        end
      end
      r.status = clipped ? gtri_pkg::ST_SATURATED : gtri_pkg::ST_INTEGRATED;
    end
    for (int a = 0; a < gtri_pkg::PORT_AXES; a++) hist_rate[a] = cur[a];
    hist_ts = s.ts;
    hist_valid = 1'b1;
    for (int a = 0; a < gtri_pkg::PORT_AXES; a++)
      r.angle[a] = (a < gtri_pkg::AXES) ? angle_acc[a] : '0;
    expected_angles.push_back(r);
  endtask

  task automatic queue_sample(input logic [gtri_pkg::TS_W-1:0] ts,
                              input logic [gtri_pkg::IN_RATE_W-1:0] x,
                              input logic [gtri_pkg::IN_RATE_W-1:0] y,
                              input logic [gtri_pkg::IN_RATE_W-1:0] z,
                              input logic restart, input logic clear);
    sample_t s;
    s.ts      = ts;
    s.rate[0] = x;
    s.rate[1] = y;
    s.rate[2] = z;
    s.restart = restart;
    s.clear   = clear;
    pending_samples.push_back(s);
    gen_ts = ts;
  endtask

  function automatic logic [gtri_pkg::IN_RATE_W-1:0] random_rate();
    case ($urandom_range(9))
      0:       return RATE_POS_MAX;
      1:       return RATE_NEG_MIN;
      2:       return gtri_pkg::IN_RATE_W'($urandom_range(64)) - gtri_pkg::IN_RATE_W'(32);
      default: return gtri_pkg::IN_RATE_W'($urandom);
    endcase
  endfunction

  task automatic write_gap(input logic [gtri_pkg::GAP_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    gap_limit = value;
  endtask

  // checked between edges so that the driver's updates have settled
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || expected_angles.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_samples
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        integrate_sample(on_offer);
        busy = 1'b0;
      end
      if (!busy && pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
        on_offer = pending_samples.pop_front();
        in_valid_i     <= 1'b1;
        timestamp_ns_i <= on_offer.ts;
        rate_x_i       <= on_offer.rate[0];
        rate_y_i       <= on_offer.rate[1];
        rate_z_i       <= on_offer.rate[2];
        restart_i      <= on_offer.restart;
        clear_angle_i  <= on_offer.clear;
      end else if (!busy) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_off_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    angle_result_t                want;
    logic [gtri_pkg::ANGLE_W-1:0] got [gtri_pkg::PORT_AXES];
    if (rst_ni && out_valid_o && out_ready_i) begin
      got[0] = angle_x_o;
      got[1] = angle_y_o;
      got[2] = angle_z_o;
      if (expected_angles.size() == 0) begin
        report_mismatch("unrequested result", '0, 64'(step_status_o));
      end else begin
        want = expected_angles.pop_front();
        for (int a = 0; a < gtri_pkg::PORT_AXES; a++) begin
          if (got[a] !== want.angle[a])
            report_mismatch($sformatf("angle[%0d]", a), want.angle[a], got[a]);
        end
        if (step_status_o !== want.status)
          report_mismatch("step_status", 64'(want.status), 64'(step_status_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("[gyro_rate_trapezoid_integrator_top] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [63:0]                step;
    logic [gtri_pkg::GAP_W-1:0] span;
    logic [gtri_pkg::GAP_W-1:0] g;
    logic [gtri_pkg::TS_W-1:0]  ts;
    int unsigned                pick;
    for (int a = 0; a < gtri_pkg::PORT_AXES; a++) begin
      hist_rate[a] = '0;
      angle_acc[a] = '0;
    end
    hist_ts    = '0;
    hist_valid = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, gap limit at its reset value
    queue_sample(63'd1000, RATE_POS_MAX, RATE_NEG_MIN, '0, 1'b0, 1'b0);
    queue_sample(63'd2000, RATE_POS_MAX, RATE_POS_MAX, RATE_NEG_MIN, 1'b0, 1'b0);
    queue_sample(63'd2000, 24'h000123, 24'hFFF000, 24'h00FFFF, 1'b0, 1'b0);
    queue_sample(63'd1500, 24'h001000, 24'hFFF800, 24'h000001, 1'b0, 1'b0);
    queue_sample(63'd100001500, 24'h001000, 24'hFFF800, 24'h000001, 1'b0, 1'b0);
    queue_sample(63'd200001501, 24'h7FF000, 24'h812345, 24'h3FFFFF, 1'b0, 1'b0);
    queue_sample(63'd200001511, 24'h000200, 24'h000300, 24'h000400, 1'b1, 1'b0);
    queue_sample(63'd200001521, 24'hFFFF00, 24'h000010, 24'hABCDEF, 1'b0, 1'b1);
    queue_sample(63'd200001531, 24'h123456, 24'h654321, 24'h0F0F0F, 1'b1, 1'b1);
    queue_sample(63'h7FFF_FFFF_FFFF_FFFF, RATE_NEG_MIN, RATE_POS_MAX, 24'hF0F0F0, 1'b0, 1'b0);
    queue_sample(63'd0, 24'h000001, 24'hFFFFFF, '0, 1'b0, 1'b0);
    queue_sample(63'd1, 24'hFFFFFF, 24'h000001, 24'h555555, 1'b0, 1'b0);
    queue_sample(63'h4000_0000_0000_0000, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1, 1'b0);
    queue_sample(63'h4000_0000_0000_0005, 24'h2AAAAA, 24'hD55555, '0, 1'b0, 1'b0);
    drain();

    // zero gap limit: nothing passes
    write_gap('0);
    queue_sample(63'd100, 24'h000100, 24'h000200, 24'h000300, 1'b1, 1'b1);
    queue_sample(63'd101, 24'h000100, 24'h000200, 24'h000300, 1'b0, 1'b0);
    queue_sample(63'd101, 24'h000100, 24'h000200, 24'h000300, 1'b0, 1'b0);
    queue_sample(63'd50, 24'h000100, 24'h000200, 24'h000300, 1'b0, 1'b0);
    drain();

    write_gap(gtri_pkg::GAP_W'(1));
    queue_sample(63'd200, RATE_POS_MAX, RATE_NEG_MIN, 24'h000007, 1'b1, 1'b0);
    queue_sample(63'd201, RATE_POS_MAX, RATE_NEG_MIN, 24'hFFFFF9, 1'b0, 1'b0);
    queue_sample(63'd203, 24'h000010, 24'h000020, 24'h000030, 1'b0, 1'b0);
    queue_sample(63'd204, 24'h000010, 24'h000020, 24'h000030, 1'b0, 1'b0);
    drain();

    // drive to both limits at the widest gap; no idling, one long hold-off
    write_gap('1);
    idle_pct = 0;
    hold_off_req = 1'b1;
    queue_sample(gen_ts + 63'd1, RATE_POS_MAX, RATE_POS_MAX, RATE_POS_MAX, 1'b1, 1'b1);
    repeat (135)
      queue_sample(gen_ts + gtri_pkg::TS_W'(32'hFFFF_FFFF - $urandom_range(15)),
                   RATE_POS_MAX - gtri_pkg::IN_RATE_W'($urandom_range(7)),
                   RATE_POS_MAX - gtri_pkg::IN_RATE_W'($urandom_range(7)),
                   RATE_POS_MAX - gtri_pkg::IN_RATE_W'($urandom_range(7)), 1'b0, 1'b0);
    repeat (270)
      queue_sample(gen_ts + gtri_pkg::TS_W'(32'hFFFF_FFFF - $urandom_range(15)),
                   RATE_NEG_MIN + gtri_pkg::IN_RATE_W'($urandom_range(7)),
                   RATE_NEG_MIN + gtri_pkg::IN_RATE_W'($urandom_range(7)),
                   RATE_NEG_MIN + gtri_pkg::IN_RATE_W'($urandom_range(7)), 1'b0, 1'b0);
    drain();
    idle_pct = IDLE_PCT;

    // random sequences under several gap limits
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       g = gtri_pkg::GAP_W'(1000);
        1:       g = '1;
        2:       g = gtri_pkg::GAP_W'(1);
        3:       g = gtri_pkg::MAX_GAP_RESET;
        default: g = gtri_pkg::GAP_W'($urandom_range(32'hFFFF_FFFF, 1));
      endcase
      write_gap(g);
      repeat (240) begin
        pick = $urandom_range(99);
        span = (gap_limit > 1000 && $urandom_range(1) == 1) ? gtri_pkg::GAP_W'(1000)
                                                            : gap_limit;
        step = 64'($urandom_range(span, 1));
        if (pick < 8) step = 64'(gap_limit) + 64'($urandom_range(1000, 1));
        else if (pick < 13) step = '0;
        else if (pick < 18) step = -64'($urandom_range(100000, 1));
        ts = gen_ts + step[gtri_pkg::TS_W-1:0];
        if (pick >= 96) ts = gtri_pkg::TS_W'({$urandom, $urandom});
        queue_sample(ts, random_rate(), random_rate(), random_rate(),
                     $urandom_range(99) < 4, $urandom_range(99) < 4);
      end
      drain();
    end

    if (mismatch_count == 0 && expected_angles.size() == 0)
      $display("[gyro_rate_trapezoid_integrator_top] OK");
    else
      $display("[gyro_rate_trapezoid_integrator_top] ERROR");
    $finish;
  end

endmodule
